### hdl/cir_pkg.sv
// shared types and constants for the contact impulse resolver
`default_nettype none
package cir_pkg;

	localparam int COMPONENT_WIDTH_DEF = 20;
	localparam int VEC_W   = 60;
	localparam int MASS_W  = 24;
	localparam int TOT_W   = MASS_W + 1;
	localparam int DEPTH_W = 20;
	localparam int REST_W  = 16;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 2;
	localparam int QUO_W   = 28;
	localparam int NUM_W   = QUO_W + MASS_W;
	localparam int DIV_LANES = 4;

	localparam logic [IDX_W-1:0] REG_RESTITUTION = 2'd0;
	localparam logic [IDX_W-1:0] REG_MIN_TOTAL   = 2'd1;

	localparam logic [1:0] OUT_CHANGED    = 2'd0;
	localparam logic [1:0] OUT_SEPARATING = 2'd1;
	localparam logic [1:0] OUT_IMMOVABLE  = 2'd2;

	localparam int LANE_POS_A = 0;
	localparam int LANE_POS_B = 1;
	localparam int LANE_VEL_A = 2;
	localparam int LANE_VEL_B = 3;

	typedef struct packed {
		logic                with_object_b;
		logic [VEC_W-1:0]    pos_a;
		logic [VEC_W-1:0]    vel_a;
		logic [MASS_W-1:0]   inv_mass_a;
		logic [VEC_W-1:0]    pos_b;
		logic [VEC_W-1:0]    vel_b;
		logic [MASS_W-1:0]   inv_mass_b;
		logic [VEC_W-1:0]    contact_normal;
		logic [DEPTH_W-1:0]  depth;
		logic [VEC_W-1:0]    world_point;
	} item_t;

	typedef struct packed {
		logic [VEC_W-1:0] new_pos_a;
		logic [VEC_W-1:0] new_vel_a;
		logic [VEC_W-1:0] new_pos_b;
		logic [VEC_W-1:0] new_vel_b;
		logic [1:0]       outcome;
	} result_t;

	typedef struct packed {
		logic               with_b;
		logic               immov;
		logic               neg;
		logic [TOT_W-1:0]   total;
		logic [QUO_W-1:0]   d;
		logic [VEC_W-1:0]   pos_a;
		logic [VEC_W-1:0]   vel_a;
		logic [VEC_W-1:0]   pos_b;
		logic [VEC_W-1:0]   vel_b;
		logic [VEC_W-1:0]   normal;
		logic [VEC_W-1:0]   world_point;
	} ctx_t;

	typedef struct packed {
		logic [TOT_W-1:0] rem;
		logic [QUO_W-1:0] low;
		logic [QUO_W-1:0] quo;
	} div_lane_t;

	function automatic div_lane_t div_step(div_lane_t x, logic [TOT_W-1:0] den);
		logic [TOT_W:0] trial;
		logic           ge;
		div_lane_t      y;
		trial = {x.rem, x.low[QUO_W-1]};
		ge = (trial >= {1'b0, den});
		y.rem = ge ? TOT_W'(trial - {1'b0, den}) : trial[TOT_W-1:0];
		y.low = {x.low[QUO_W-2:0], 1'b0};
		y.quo = {x.quo[QUO_W-2:0], ge};
		return y;
	endfunction

endpackage
`default_nettype wire

### hdl/cir_front.sv
// front stages: separating velocity, restitution delta and divider numerators
`default_nettype none
module cir_front #(
	parameter int COMPONENT_WIDTH = cir_pkg::COMPONENT_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_vld,
	input  wire cir_pkg::item_t               item,
	input  wire logic [cir_pkg::REST_W-1:0]   restitution,
	input  wire logic [cir_pkg::MASS_W-1:0]   min_total,
	output logic                              out_vld,
	output logic [cir_pkg::DIV_LANES-1:0][cir_pkg::NUM_W-1:0] num,
	output cir_pkg::ctx_t                     ctx
);
	import cir_pkg::*;

	localparam int W     = COMPONENT_WIDTH;
	localparam int SEP_W = 2 * W + 3;
	localparam int LO_W  = 22;
	localparam int EP_W  = REST_W + 1;
	localparam int FW    = SEP_W + EP_W + 1;
	localparam int PP_W  = DEPTH_W + MASS_W;

	logic [62:0] vel_a_x, vel_b_x, nrm_x;
	logic signed [W-1:0] va [3];
	logic signed [W-1:0] vb [3];
	logic signed [W-1:0] nn [3];
	logic signed [W:0]   dv [3];
	logic signed [2*W:0] vp [3];

	assign vel_a_x = {3'b0, item.vel_a};
	assign vel_b_x = {3'b0, item.vel_b};
	assign nrm_x   = {3'b0, item.contact_normal};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = vel_a_x[i*W +: W];
			vb[i] = item.with_object_b ? vel_b_x[i*W +: W] : '0;
			nn[i] = nrm_x[i*W +: W];
			dv[i] = (W+1)'(va[i]) - (W+1)'(vb[i]);
			vp[i] = dv[i] * (2*W+1)'(nn[i]);
		end
	end

	logic [TOT_W-1:0] total;
	assign total = TOT_W'(item.inv_mass_a) + TOT_W'(item.inv_mass_b);

	// stage 1
	logic                vld_s1;
	ctx_t                ctx_s1;
	logic signed [2*W:0] vp_s1 [3];
	logic [MASS_W-1:0]   ia_s1, ib_s1;
	logic [PP_W-1:0]     ppa_s1, ppb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		ctx_s1.with_b      <= item.with_object_b;
		ctx_s1.immov       <= item.with_object_b &&
			(total == '0 || total < TOT_W'(min_total));
		ctx_s1.neg         <= 1'b0;
		ctx_s1.total       <= total;
		ctx_s1.d           <= '0;
		ctx_s1.pos_a       <= item.pos_a;
		ctx_s1.vel_a       <= item.vel_a;
		ctx_s1.pos_b       <= item.pos_b;
		ctx_s1.vel_b       <= item.vel_b;
		ctx_s1.normal      <= item.contact_normal;
		ctx_s1.world_point <= item.world_point;
		for (int i = 0; i < 3; i++) vp_s1[i] <= vp[i];
		ia_s1  <= item.inv_mass_a;
		ib_s1  <= item.inv_mass_b;
		ppa_s1 <= PP_W'(item.depth) * PP_W'(item.inv_mass_a);
		ppb_s1 <= PP_W'(item.depth) * PP_W'(item.inv_mass_b);
	end

	// stage 2
	logic signed [SEP_W-1:0] sep;
	assign sep = SEP_W'(vp_s1[0]) + SEP_W'(vp_s1[1]) + SEP_W'(vp_s1[2]);

	ctx_t ctx_n2;
	always_comb begin
		ctx_n2     = ctx_s1;
		ctx_n2.neg = sep[SEP_W-1];
	end

	logic              vld_s2;
	ctx_t              ctx_s2;
	logic [SEP_W-1:0]  mag_s2;
	logic [MASS_W-1:0] ia_s2, ib_s2;
	logic [PP_W-1:0]   ppa_s2, ppb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		ctx_s2     <= ctx_n2;
		mag_s2     <= SEP_W'(-sep);
		ia_s2      <= ia_s1;
		ib_s2      <= ib_s1;
		ppa_s2     <= ppa_s1;
		ppb_s2     <= ppb_s1;
	end

	// stage 3
	logic [EP_W-1:0] ep;
	assign ep = EP_W'(32768) + EP_W'(restitution);

	logic                   vld_s3;
	ctx_t                   ctx_s3;
	logic [LO_W+EP_W-1:0]   pl_s3;
	logic [SEP_W-LO_W+EP_W-1:0] ph_s3;
	logic [MASS_W-1:0]      ia_s3, ib_s3;
	logic [PP_W-1:0]        ppa_s3, ppb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		ctx_s3 <= ctx_s2;
		pl_s3  <= (LO_W+EP_W)'(mag_s2[LO_W-1:0]) * (LO_W+EP_W)'(ep);
		ph_s3  <= (SEP_W-LO_W+EP_W)'(mag_s2[SEP_W-1:LO_W]) * (SEP_W-LO_W+EP_W)'(ep);
		ia_s3  <= ia_s2;
		ib_s3  <= ib_s2;
		ppa_s3 <= ppa_s2;
		ppb_s3 <= ppb_s2;
	end

	// stage 4
	logic [FW-1:0] full;
	assign full = FW'(pl_s3) + (FW'(ph_s3) << LO_W) + (FW'(1) << 32);

	ctx_t ctx_n4;
	always_comb begin
		ctx_n4   = ctx_s3;
		ctx_n4.d = QUO_W'(full >> 33);
	end

	logic              vld_s4;
	ctx_t              ctx_s4;
	logic [MASS_W-1:0] ia_s4, ib_s4;
	logic [PP_W-1:0]   ppa_s4, ppb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		ctx_s4   <= ctx_n4;
		ia_s4    <= ia_s3;
		ib_s4    <= ib_s3;
		ppa_s4   <= ppa_s3;
		ppb_s4   <= ppb_s3;
	end

	// stage 5
	logic vld_s5;
	ctx_t ctx_s5;
	logic [DIV_LANES-1:0][NUM_W-1:0] num_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		ctx_s5 <= ctx_s4;
		num_s5[LANE_POS_A] <= NUM_W'(ppa_s4);
		num_s5[LANE_POS_B] <= NUM_W'(ppb_s4);
		num_s5[LANE_VEL_A] <= NUM_W'(ctx_s4.d) * NUM_W'(ia_s4);
		num_s5[LANE_VEL_B] <= NUM_W'(ctx_s4.d) * NUM_W'(ib_s4);
	end

	assign out_vld = vld_s5;
	assign num     = num_s5;
	assign ctx     = ctx_s5;

endmodule
`default_nettype wire

### hdl/cir_divider.sv
// pipelined restoring divider, one quotient bit per stage, shared denominator
`default_nettype none
module cir_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_vld,
	input  wire logic [cir_pkg::DIV_LANES-1:0][cir_pkg::NUM_W-1:0] num,
	input  wire cir_pkg::ctx_t                in_ctx,
	output logic                              out_vld,
	output logic [cir_pkg::DIV_LANES-1:0][cir_pkg::QUO_W-1:0] quo,
	output cir_pkg::ctx_t                     out_ctx
);
	import cir_pkg::*;

	localparam int STAGES = QUO_W;

	logic      vld_s  [STAGES];
	ctx_t      ctx_s  [STAGES];
	div_lane_t lane_s [STAGES][DIV_LANES];

	div_lane_t init [DIV_LANES];

	always_comb begin
		for (int l = 0; l < DIV_LANES; l++) begin
			init[l].rem = TOT_W'(num[l][NUM_W-1:QUO_W]);
			init[l].low = num[l][QUO_W-1:0];
			init[l].quo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < STAGES; s++) vld_s[s] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
			for (int s = 1; s < STAGES; s++) vld_s[s] <= vld_s[s-1];
		end
	end

	always_ff @(posedge clk) begin
		ctx_s[0] <= in_ctx;
		for (int l = 0; l < DIV_LANES; l++)
			lane_s[0][l] <= div_step(init[l], in_ctx.total);
		for (int s = 1; s < STAGES; s++) begin
			ctx_s[s] <= ctx_s[s-1];
			for (int l = 0; l < DIV_LANES; l++)
				lane_s[s][l] <= div_step(lane_s[s-1][l], ctx_s[s-1].total);
		end
	end

	always_comb begin
		for (int l = 0; l < DIV_LANES; l++) quo[l] = lane_s[STAGES-1][l].quo;
	end

	assign out_vld = vld_s[STAGES-1];
	assign out_ctx = ctx_s[STAGES-1];

endmodule
`default_nettype wire

### hdl/cir_back.sv
// back stages: scaled normal products, rounding, saturation and result register
`default_nettype none
module cir_back #(
	parameter int COMPONENT_WIDTH = cir_pkg::COMPONENT_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_vld,
	input  wire logic [cir_pkg::DIV_LANES-1:0][cir_pkg::QUO_W-1:0] quo,
	input  wire cir_pkg::ctx_t                ctx,
	output logic                              done,
	output cir_pkg::result_t                  result
);
	import cir_pkg::*;

	localparam int W  = COMPONENT_WIDTH;
	localparam int PW = W + QUO_W + 1;
	localparam int SW = PW + 1;

	function automatic logic [W-1:0] sat(logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi, lo;
		hi = SW'((64'sd1 <<< (W-1)) - 64'sd1);
		lo = -hi - SW'(1);
		if (v > hi) return W'(hi);
		if (v < lo) return W'(lo);
		return W'(v);
	endfunction

	logic [62:0] nrm_x;
	logic signed [W-1:0] nn [3];
	logic [QUO_W-1:0] qsel [DIV_LANES];

	assign nrm_x = {3'b0, ctx.normal};

	always_comb begin
		for (int i = 0; i < 3; i++) nn[i] = nrm_x[i*W +: W];
		qsel[LANE_POS_A] = quo[LANE_POS_A];
		qsel[LANE_POS_B] = quo[LANE_POS_B];
		qsel[LANE_VEL_A] = ctx.with_b ? quo[LANE_VEL_A] : ctx.d;
		qsel[LANE_VEL_B] = quo[LANE_VEL_B];
	end

	// stage b1
	logic              vld_s1;
	ctx_t              ctx_s1;
	logic signed [PW-1:0] p_s1 [DIV_LANES][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= ctx;
		for (int l = 0; l < DIV_LANES; l++)
			for (int i = 0; i < 3; i++)
				p_s1[l][i] <= PW'(nn[i]) * $signed({1'b0, qsel[l]});
	end

	// stage b2
	logic [62:0] pa_x, va_x, pb_x, vb_x, wp_x;
	logic signed [SW-1:0] r [DIV_LANES][3];
	logic [3*W-1:0] npa, nva, npb, nvb;
	logic move_pos, move_va, move_vb;
	logic [1:0] outcome;

	assign pa_x = {3'b0, ctx_s1.pos_a};
	assign va_x = {3'b0, ctx_s1.vel_a};
	assign pb_x = {3'b0, ctx_s1.pos_b};
	assign vb_x = {3'b0, ctx_s1.vel_b};
	assign wp_x = {3'b0, ctx_s1.world_point};

	assign move_pos = ctx_s1.with_b && !ctx_s1.immov;
	assign move_va  = ctx_s1.neg && !ctx_s1.immov;
	assign move_vb  = ctx_s1.with_b && ctx_s1.neg && !ctx_s1.immov;

	always_comb begin
		for (int l = 0; l < DIV_LANES; l++)
			for (int i = 0; i < 3; i++)
				r[l][i] = SW'((p_s1[l][i] + PW'(1 << 17)) >>> 18);
		for (int i = 0; i < 3; i++) begin
			logic signed [W-1:0] pa, va, pb, vb, wp;
			pa = pa_x[i*W +: W];
			va = va_x[i*W +: W];
			pb = pb_x[i*W +: W];
			vb = vb_x[i*W +: W];
			wp = wp_x[i*W +: W];
			npa[i*W +: W] = !ctx_s1.with_b ? wp :
				sat(SW'(pa) + (move_pos ? r[LANE_POS_A][i] : SW'(0)));
			npb[i*W +: W] = sat(SW'(pb) - (move_pos ? r[LANE_POS_B][i] : SW'(0)));
			nva[i*W +: W] = sat(SW'(va) + (move_va ? r[LANE_VEL_A][i] : SW'(0)));
			nvb[i*W +: W] = sat(SW'(vb) - (move_vb ? r[LANE_VEL_B][i] : SW'(0)));
		end
		if (ctx_s1.immov) outcome = OUT_IMMOVABLE;
		else if (ctx_s1.neg) outcome = OUT_CHANGED;
		else outcome = OUT_SEPARATING;
	end

	logic    vld_s2;
	result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		res_s2.new_pos_a <= VEC_W'(63'(npa));
		res_s2.new_vel_a <= VEC_W'(63'(nva));
		res_s2.new_pos_b <= VEC_W'(63'(npb));
		res_s2.new_vel_b <= VEC_W'(63'(nvb));
		res_s2.outcome   <= outcome;
	end

	assign done   = vld_s2;
	assign result = res_s2;

endmodule
`default_nettype wire

### hdl/contact_impulse_resolver.sv
// top level of the contact impulse resolver
//
// one contact enters as a transaction on cmd when start is high and busy is
// low; busy is never raised, so a contact can be issued in every cycle.
// each result appears on result for exactly one cycle with done high, in
// issue order. throughput is one contact per cycle; the pipeline holds the
// 28-stage restoring divider that splits depth and restitution delta by
// inverse-mass fraction, plus five front stages and two back stages.
// configuration is written through cfg_we, cfg_index and cfg_data while no
// contact is in flight; index 0 is restitution, index 1 the minimum summed
// inverse mass, other indexes are ignored.
// reset clears all valid bits, so nothing is reported until a new contact
// arrives, and loads restitution 0.5 and threshold 1.
// the receiver cannot stall: a result must be taken in its done cycle.
`default_nettype none
module contact_impulse_resolver #(
	parameter int COMPONENT_WIDTH = cir_pkg::COMPONENT_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire cir_pkg::item_t              cmd,
	output logic                             done,
	output cir_pkg::result_t                 result,
	input  wire logic                        cfg_we,
	input  wire logic [cir_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [cir_pkg::CFG_W-1:0]   cfg_data
);
	import cir_pkg::*;

	logic [REST_W-1:0] restitution_q;
	logic [MASS_W-1:0] min_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= REST_W'(16384);
			min_total_q   <= MASS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RESTITUTION: restitution_q <= cfg_data[REST_W-1:0];
				REG_MIN_TOTAL:   min_total_q   <= cfg_data[MASS_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic in_vld;
	assign in_vld = start && !busy;

	logic front_vld, div_vld;
	logic [DIV_LANES-1:0][NUM_W-1:0] num;
	logic [DIV_LANES-1:0][QUO_W-1:0] quo;
	ctx_t front_ctx, div_ctx;

	cir_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (in_vld),
		.item        (cmd),
		.restitution (restitution_q),
		.min_total   (min_total_q),
		.out_vld     (front_vld),
		.num         (num),
		.ctx         (front_ctx)
	);

	cir_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (front_vld),
		.num     (num),
		.in_ctx  (front_ctx),
		.out_vld (div_vld),
		.quo     (quo),
		.out_ctx (div_ctx)
	);

	cir_back #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (div_vld),
		.quo    (quo),
		.ctx    (div_ctx),
		.done   (done),
		.result (result)
	);

endmodule
`default_nettype wire

### tb/tb_contact_impulse_resolver.sv
// self-checking testbench for the contact impulse resolver with a built-in fixed-point predictor
`default_nettype none
module tb_contact_impulse_resolver;
	import cir_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = COMPONENT_WIDTH_DEF;
	localparam longint CMAX = (longint'(1) << (W - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t cmd;
	logic done;
	result_t result;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	longint unsigned rest_coef;
	longint unsigned min_total;
	result_t expected_q[$];
	int errors;
	bit no_gaps;

	contact_impulse_resolver i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_contact_impulse_resolver: done, errors");
		$finish;
	end

	function automatic longint comp(logic [VEC_W-1:0] v, int i);
		logic [W-1:0] u;
		u = v[i*W +: W];
		return longint'($signed(u));
	endfunction

	function automatic longint sat(longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	function automatic longint rnd18(longint v);
		return (v + (longint'(1) << 17)) >>> 18;
	endfunction

	function automatic logic [VEC_W-1:0] pack_vec(longint c[3]);
		logic [VEC_W-1:0] r;
		logic [W-1:0] u;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			u = W'(sat(c[i]));
			r[i*W +: W] = u;
		end
		return r;
	endfunction

	function automatic result_t predict_contact(item_t it);
		result_t r;
		longint pa[3], va[3], pb[3], vb[3], n[3];
		longint unsigned ia, ib, total, d, da, db;
		longint sep;
		logic [1:0] oc;
		ia = it.inv_mass_a;
		ib = it.inv_mass_b;
		total = ia + ib;
		sep = 0;
		oc = OUT_SEPARATING;
		for (int i = 0; i < 3; i++) begin
			pa[i] = comp(it.pos_a, i);
			va[i] = comp(it.vel_a, i);
			pb[i] = comp(it.pos_b, i);
			vb[i] = comp(it.vel_b, i);
			n[i] = comp(it.contact_normal, i);
		end
		if (it.with_object_b) begin
			if (total == 0 || total < min_total) begin
				oc = OUT_IMMOVABLE;
			end else begin
				da = (longint'(it.depth) * ia) / total;
				db = (longint'(it.depth) * ib) / total;
				for (int i = 0; i < 3; i++) begin
					pa[i] = sat(pa[i] + rnd18(n[i] * longint'(da)));
					pb[i] = sat(pb[i] - rnd18(n[i] * longint'(db)));
					sep += (va[i] - vb[i]) * n[i];
				end
				if (sep < 0) begin
					d = (longint'(-sep) * (32768 + rest_coef) + (longint'(1) << 32)) >> 33;
					da = (d * ia) / total;
					db = (d * ib) / total;
					for (int i = 0; i < 3; i++) begin
						va[i] = sat(va[i] + rnd18(n[i] * longint'(da)));
						vb[i] = sat(vb[i] - rnd18(n[i] * longint'(db)));
					end
					oc = OUT_CHANGED;
				end
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				pa[i] = comp(it.world_point, i);
				sep += va[i] * n[i];
			end
			if (sep < 0) begin
				d = (longint'(-sep) * (32768 + rest_coef) + (longint'(1) << 32)) >> 33;
				for (int i = 0; i < 3; i++)
					va[i] = sat(va[i] + rnd18(n[i] * longint'(d)));
				oc = OUT_CHANGED;
			end
		end
		r.new_pos_a = pack_vec(pa);
		r.new_vel_a = pack_vec(va);
		r.new_pos_b = pack_vec(pb);
		r.new_vel_b = pack_vec(vb);
		r.outcome = oc;
		return r;
	endfunction

	task automatic compare_field(string name, logic [VEC_W-1:0] exp_v, logic [VEC_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected transaction actual %h", $time, result);
				errors++;
			end else begin
				e = expected_q.pop_front();
				compare_field("new_pos_a", e.new_pos_a, result.new_pos_a);
				compare_field("new_vel_a", e.new_vel_a, result.new_vel_a);
				compare_field("new_pos_b", e.new_pos_b, result.new_pos_b);
				compare_field("new_vel_b", e.new_vel_b, result.new_vel_b);
				compare_field("outcome", VEC_W'(e.outcome), VEC_W'(result.outcome));
			end
		end
	end

	function automatic int pick_gap();
		if (no_gaps || $urandom_range(0, 9) < 7) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_contact(item_t it);
		int gap;
		cmd <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_q.push_back(predict_contact(it));
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RESTITUTION) rest_coef = val[REST_W-1:0];
		else if (idx == REG_MIN_TOTAL) min_total = val;
	endtask

	function automatic logic [VEC_W-1:0] rand_vec(int mag);
		logic [VEC_W-1:0] v;
		if ($urandom_range(0, 9) == 0) return VEC_W'({$urandom, $urandom});
		v = '0;
		for (int i = 0; i < 3; i++)
			v[i*W +: W] = W'($urandom_range(0, 2 * mag) - mag);
		return v;
	endfunction

	function automatic logic [VEC_W-1:0] rand_normal();
		logic [VEC_W-1:0] v;
		int axis;
		if ($urandom_range(0, 3) == 0) return rand_vec(1 << 19);
		v = '0;
		axis = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++)
			v[i*W +: W] = W'(int'($urandom_range(0, 40000)) - 20000);
		v[axis*W +: W] = W'(($urandom_range(0, 1) ? 1 : -1) * (1 << 18));
		return v;
	endfunction

	function automatic logic [MASS_W-1:0] rand_mass();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return MASS_W'($urandom_range(0, 15));
			2: return MASS_W'($urandom);
			default: return MASS_W'($urandom_range(1 << 12, 1 << 18));
		endcase
	endfunction

	function automatic item_t rand_contact();
		item_t it;
		it.with_object_b = $urandom_range(0, 3) != 0;
		it.pos_a = rand_vec(1 << 18);
		it.vel_a = rand_vec(1 << 14);
		it.inv_mass_a = rand_mass();
		it.pos_b = rand_vec(1 << 18);
		it.vel_b = rand_vec(1 << 14);
		it.inv_mass_b = rand_mass();
		it.contact_normal = rand_normal();
		it.depth = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(0, 4096));
		it.world_point = rand_vec(1 << 18);
		return it;
	endfunction

	task automatic test_directed();
		item_t it;
		logic [VEC_W-1:0] maxv, minv, unitx;
		maxv = {3{1'b0, {(W-1){1'b1}}}};
		minv = {3{1'b1, {(W-1){1'b0}}}};
		unitx = VEC_W'(1 << 18);
		it = '0;
		it.with_object_b = 1'b1;
		send_contact(it);
		it.inv_mass_a = '1;
		it.inv_mass_b = '1;
		it.depth = '1;
		it.contact_normal = maxv;
		it.pos_a = maxv;
		it.pos_b = minv;
		it.vel_a = minv;
		it.vel_b = maxv;
		send_contact(it);
		it.contact_normal = minv;
		send_contact(it);
		it.inv_mass_a = 24'd1 << 16;
		it.inv_mass_b = '0;
		it.contact_normal = unitx;
		it.vel_a = VEC_W'(-2048);
		it.vel_b = '0;
		it.pos_a = '0;
		it.pos_b = '0;
		it.depth = 20'd1024;
		send_contact(it);
		it.vel_a = VEC_W'(2048);
		send_contact(it);
		it.inv_mass_b = 24'd1 << 16;
		send_contact(it);
		it.with_object_b = 1'b0;
		it.world_point = maxv;
		it.vel_a = VEC_W'(-4096);
		send_contact(it);
		it.world_point = minv;
		it.vel_a = VEC_W'(4096);
		send_contact(it);
		it.vel_a = minv;
		it.contact_normal = maxv;
		send_contact(it);
		it.contact_normal = {3{20'h7ffff}} ^ {3{20'h3ffff}};
		send_contact(it);
		it = '1;
		send_contact(it);
		it.with_object_b = 1'b0;
		send_contact(it);
	endtask

	task automatic test_immovable();
		item_t it;
		write_reg(REG_MIN_TOTAL, 24'd100);
		it = rand_contact();
		it.with_object_b = 1'b1;
		it.inv_mass_a = 24'd50;
		it.inv_mass_b = 24'd49;
		send_contact(it);
		it.inv_mass_b = 24'd50;
		send_contact(it);
		it.inv_mass_a = '0;
		it.inv_mass_b = '0;
		send_contact(it);
	endtask

	task automatic test_random(int count, bit steady);
		no_gaps = steady;
		repeat (count) send_contact(rand_contact());
		no_gaps = 1'b0;
	endtask

	initial begin
		errors = 0;
		no_gaps = 0;
		rest_coef = 16384;
		min_total = 1;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200, 1'b0);
		test_immovable();
		write_reg(REG_RESTITUTION, 24'd0);
		write_reg(REG_MIN_TOTAL, 24'd0);
		test_random(200, 1'b1);
		write_reg(REG_RESTITUTION, 24'd32768);
		test_random(200, 1'b0);
		write_reg(REG_RESTITUTION, 24'hffffff);
		write_reg(REG_MIN_TOTAL, 24'hffffff);
		test_random(200, 1'b0);
		write_reg(IDX_W'(2), 24'h5a5a5a);
		write_reg(IDX_W'(3), 24'ha5a5a5);
		write_reg(REG_MIN_TOTAL, 24'd1 << 16);
		write_reg(REG_RESTITUTION, 24'd12345);
		test_random(250, 1'b0);
		write_reg(REG_MIN_TOTAL, 24'd1);
		write_reg(REG_RESTITUTION, 24'd16384);
		test_random(280, 1'b0);
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_contact_impulse_resolver: done, clean");
		else
			$display("tb_contact_impulse_resolver: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
hdl/cir_pkg.sv
hdl/cir_front.sv
hdl/cir_divider.sv
hdl/cir_back.sv
hdl/contact_impulse_resolver.sv
tb/tb_contact_impulse_resolver.sv
